/* rtl/tskf_pkg.sv */
// Shared types and fixed-point helpers for the two-state Kalman filter.
`timescale 1ns / 1ps
`default_nettype none
package tskf_pkg;

    typedef logic signed [67:0] t_wide;
    typedef logic signed [33:0] t_mop;

    // request from the sequencer to the shared divider
    typedef struct packed {
        logic               start;
        logic signed [31:0] num;
        logic        [30:0] den;
    } t_div_req;

    // result of the shared divider
    typedef struct packed {
        logic               done;
        logic signed [31:0] quot;
    } t_div_rsp;

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input t_wide x);
        if (x > 68'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (x < -68'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    // shift right rounding half up
    function automatic t_wide rnd_shift(input t_wide p, input int unsigned sh);
        t_wide bias;
        bias = 68'sd1 <<< (sh - 1);
        return (p + bias) >>> sh;
    endfunction

    function automatic t_wide ext_s32(input logic signed [31:0] x);
        return 68'(x);
    endfunction

    function automatic t_wide ext_u31(input logic [30:0] x);
        return $signed({37'd0, x});
    endfunction

    function automatic t_mop op_s32(input logic signed [31:0] x);
        return 34'(x);
    endfunction

    function automatic t_mop op_u16(input logic [15:0] x);
        return $signed({18'd0, x});
    endfunction

    function automatic t_mop op_u31(input logic [30:0] x);
        return $signed({3'd0, x});
    endfunction

endpackage
`default_nettype wire

/* rtl/two_state_kalman_filter.sv */
// Top level: two-state Kalman filter sequencer, state and result register.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one item: time step,
//   acceleration and measurement. Output channel (o_out_valid / i_out_ready)
//   gives value and rate estimates, residual, innovation variance and the
//   rejected flag, one result item per input item.
//   Configuration channel (i_cfg_valid / o_cfg_ready) is always ready;
//   index 0..3 selects process noise, measurement noise, initial covariance
//   and gate threshold. Writing the initial covariance reloads P.
//   Each item runs through the shared multiplier steps, the gate check and,
//   for an accepted correction, the serial gain divider for both gains; a
//   rejected item skips the correction. The next item is taken in the cycle
//   after the result is loaded, so the filter holds one item at a time.
//   A stalled receiver holds the finished item in the output register
//   until taken and blocks only the end of the following item.
//   Reset loads the default registers, zero estimates and diagonal P.
`timescale 1ns / 1ps
`default_nettype none
module two_state_kalman_filter
    import tskf_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int MIN_STEP     = 66,
    parameter int DEFAULT_STEP = 655
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire        [15:0] i_time_step,
    input  wire signed [31:0] i_accel,
    input  wire signed [31:0] i_measurement,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output logic signed [31:0] o_value_estimate,
    output logic signed [31:0] o_rate_estimate,
    output logic signed [31:0] o_residual_out,
    output logic       [30:0] o_innovation_var,
    output logic              o_rejected,
    input  wire               i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire        [1:0]  i_cfg_index,
    input  wire        [30:0] i_cfg_data
);

    // register indexes
    localparam logic [1:0] REG_QSTD = 2'd0;
    localparam logic [1:0] REG_RSTD = 2'd1;
    localparam logic [1:0] REG_PINI = 2'd2;
    localparam logic [1:0] REG_GATE = 2'd3;

    // sequencer steps
    localparam logic [4:0] OP_DTDT  = 5'd0;
    localparam logic [4:0] OP_QQ    = 5'd1;
    localparam logic [4:0] OP_HDT   = 5'd2;
    localparam logic [4:0] OP_HH    = 5'd3;
    localparam logic [4:0] OP_RR    = 5'd4;
    localparam logic [4:0] OP_VDT   = 5'd5;
    localparam logic [4:0] OP_AH    = 5'd6;
    localparam logic [4:0] OP_ADT   = 5'd7;
    localparam logic [4:0] OP_N00   = 5'd8;
    localparam logic [4:0] OP_N01   = 5'd9;
    localparam logic [4:0] OP_N11   = 5'd10;
    localparam logic [4:0] OP_P0DT  = 5'd11;
    localparam logic [4:0] OP_P1DD  = 5'd12;
    localparam logic [4:0] OP_P1DT  = 5'd13;
    localparam logic [4:0] OP_SQ    = 5'd14;
    localparam logic [4:0] OP_GS    = 5'd15;
    localparam logic [4:0] ST_GATE  = 5'd16;
    localparam logic [4:0] ST_DIV0  = 5'd17;
    localparam logic [4:0] ST_DIV1  = 5'd18;
    localparam logic [4:0] OP_K0R   = 5'd19;
    localparam logic [4:0] OP_K1R   = 5'd20;
    localparam logic [4:0] OP_K1P0  = 5'd21;
    localparam logic [4:0] OP_K0P0  = 5'd22;
    localparam logic [4:0] OP_K1P1  = 5'd23;
    localparam logic [4:0] OP_K0P1  = 5'd24;
    localparam logic [4:0] ST_FIN   = 5'd25;

    localparam logic [30:0] RST_ONE  = 31'd65536;
    localparam logic [30:0] RST_GATE = 31'd251658;

    // configuration
    logic [30:0] r_qstd, r_rstd, r_gate;

    // filter state
    logic signed [31:0] r_est_v, r_est_r;
    logic signed [31:0] r_p00, r_p01, r_p10, r_p11;

    // per-item working registers
    logic        [15:0] r_dt, r_dd, r_half, r_g00, r_g01;
    logic signed [31:0] r_accel, r_meas;
    logic        [30:0] r_q2, r_r2, r_n00, r_n01, r_n11;
    logic signed [35:0] r_acc;
    logic signed [31:0] r_res;
    logic        [30:0] r_s;
    logic        [62:0] r_sq;
    logic               r_rej;
    logic signed [31:0] r_k0, r_k1;

    // sequencer
    logic               r_busy, n_busy;
    logic        [4:0]  r_step, n_step;
    logic        [4:0]  r_wb_op;
    logic               r_wb_en;
    logic               r_div_go;
    logic               w_is_mul;
    logic               w_accept;
    logic               w_fin;

    t_mop     w_a, w_b;
    t_wide    w_prod;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    t_wide    w_r16, w_r17, w_rf;
    t_wide    w_svar;
    logic     w_rej;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_busy;
    assign w_accept    = i_in_valid && !r_busy;
    assign w_is_mul    = r_busy && ((r_step <= OP_GS) || ((r_step >= OP_K0R) && (r_step <= OP_K0P1)));
    assign w_fin       = r_busy && (r_step == ST_FIN) && (!o_out_valid || i_out_ready);

    // pick multiplier operands for the current step
    always_comb begin
        w_a = '0;
        w_b = '0;
        case (r_step)
            OP_DTDT: begin w_a = op_u16(r_dt);     w_b = op_u16(r_dt);   end
            OP_HH:   begin w_a = op_u16(r_half);   w_b = op_u16(r_half); end
            OP_HDT:  begin w_a = op_u16(r_half);   w_b = op_u16(r_dt);   end
            OP_QQ:   begin w_a = op_u31(r_qstd);   w_b = op_u31(r_qstd); end
            OP_RR:   begin w_a = op_u31(r_rstd);   w_b = op_u31(r_rstd); end
            OP_VDT:  begin w_a = op_s32(r_est_r);  w_b = op_u16(r_dt);   end
            OP_AH:   begin w_a = op_s32(r_accel);  w_b = op_u16(r_half); end
            OP_ADT:  begin w_a = op_s32(r_accel);  w_b = op_u16(r_dt);   end
            OP_N00:  begin w_a = op_u31(r_q2);     w_b = op_u16(r_g00);  end
            OP_N01:  begin w_a = op_u31(r_q2);     w_b = op_u16(r_g01);  end
            OP_N11:  begin w_a = op_u31(r_q2);     w_b = op_u16(r_dd);   end
            OP_P0DT: begin
                w_a = op_s32(r_p01) + op_s32(r_p10);
                w_b = op_u16(r_dt);
            end
            OP_P1DD: begin w_a = op_s32(r_p11);    w_b = op_u16(r_dd);   end
            OP_P1DT: begin w_a = op_s32(r_p11);    w_b = op_u16(r_dt);   end
            OP_SQ: begin
                w_a = r_res[31] ? -op_s32(r_res) : op_s32(r_res);
                w_b = r_res[31] ? -op_s32(r_res) : op_s32(r_res);
            end
            OP_GS:   begin w_a = op_u31(r_gate);   w_b = op_u31(r_s);    end
            OP_K0R:  begin w_a = op_s32(r_k0);     w_b = op_s32(r_res);  end
            OP_K1R:  begin w_a = op_s32(r_k1);     w_b = op_s32(r_res);  end
            OP_K1P0: begin w_a = op_s32(r_k1);     w_b = op_s32(r_p00);  end
            OP_K0P0: begin w_a = op_s32(r_k0);     w_b = op_s32(r_p00);  end
            OP_K1P1: begin w_a = op_s32(r_k1);     w_b = op_s32(r_p01);  end
            OP_K0P1: begin w_a = op_s32(r_k0);     w_b = op_s32(r_p01);  end
            default: begin w_a = '0;               w_b = '0;             end
        endcase
    end

    tskf_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_prod (w_prod)
    );

    // start the divider once on entry to each gain step
    assign w_div_req.start = r_busy && !r_div_go && ((r_step == ST_DIV0) || (r_step == ST_DIV1));
    assign w_div_req.num   = (r_step == ST_DIV0) ? r_p00 : r_p10;
    assign w_div_req.den   = r_s;

    tskf_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // rounded views of the last product
    assign w_r16  = rnd_shift(w_prod, 16);
    assign w_r17  = rnd_shift(w_prod, 17);
    assign w_rf   = rnd_shift(w_prod, FRAC_BITS);
    assign w_svar = ext_s32(r_p00) + ext_u31(r_r2);
    assign w_rej  = (r_s == '0) || ({5'd0, r_sq} > $unsigned(w_prod));

    // advance the sequencer
    always_comb begin
        n_step = r_step;
        n_busy = r_busy;
        if (w_accept) begin
            n_busy = 1'b1;
            n_step = OP_DTDT;
        end else if (r_busy) begin
            case (r_step)
                ST_GATE: n_step = w_rej ? ST_FIN : ST_DIV0;
                ST_DIV0: n_step = w_div_rsp.done ? ST_DIV1 : r_step;
                ST_DIV1: n_step = w_div_rsp.done ? OP_K0R : r_step;
                ST_FIN:  n_busy = !w_fin;
                default: n_step = 5'(r_step + 1'b1);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_step   <= OP_DTDT;
            r_wb_en  <= 1'b0;
            r_wb_op  <= OP_DTDT;
            r_div_go <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_step  <= n_step;
            r_wb_en <= w_is_mul;
            r_wb_op <= r_step;
            if (w_div_req.start) begin
                r_div_go <= 1'b1;
            end else if (w_div_rsp.done) begin
                r_div_go <= 1'b0;
            end
        end
    end

    // configuration, filter state and write-back of each product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qstd  <= RST_ONE;
            r_rstd  <= RST_ONE;
            r_gate  <= RST_GATE;
            r_est_v <= '0;
            r_est_r <= '0;
            r_p00   <= $signed({1'b0, RST_ONE});
            r_p01   <= '0;
            r_p10   <= '0;
            r_p11   <= $signed({1'b0, RST_ONE});
            r_rej   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_QSTD: r_qstd <= i_cfg_data;
                    REG_RSTD: r_rstd <= i_cfg_data;
                    REG_PINI: begin
                        r_p00  <= $signed({1'b0, i_cfg_data});
                        r_p01  <= '0;
                        r_p10  <= '0;
                        r_p11  <= $signed({1'b0, i_cfg_data});
                    end
                    REG_GATE: r_gate <= i_cfg_data;
                    default:  r_gate <= r_gate;
                endcase
            end
            // latch the item, replacing a too-short step
            if (w_accept) begin
                r_dt    <= (i_time_step < 16'(MIN_STEP)) ? 16'(DEFAULT_STEP) : i_time_step;
                r_accel <= i_accel;
                r_meas  <= i_measurement;
            end
            if (r_busy && (r_step == ST_DIV0) && w_div_rsp.done) begin
                r_k0 <= w_div_rsp.quot;
            end
            if (r_busy && (r_step == ST_DIV1) && w_div_rsp.done) begin
                r_k1 <= w_div_rsp.quot;
            end
            if (r_wb_en) begin
                case (r_wb_op)
                    OP_DTDT: begin
                        r_dd   <= w_r16[15:0];
                        r_half <= w_r17[15:0];
                    end
                    OP_HH:   r_g00 <= w_r16[15:0];
                    OP_HDT:  r_g01 <= w_r16[15:0];
                    OP_QQ:   r_q2  <= 31'(sat32(w_rf));
                    OP_RR:   r_r2  <= 31'(sat32(w_rf));
                    OP_VDT:  r_acc <= 36'(ext_s32(r_est_v) + w_r16);
                    OP_AH:   r_est_v <= sat32(68'(r_acc) + w_r16);
                    OP_ADT:  r_est_r <= sat32(ext_s32(r_est_r) + w_r16);
                    // residual against the predicted value
                    OP_N00: begin
                        r_n00 <= w_r16[30:0];
                        r_res <= sat32(ext_s32(r_meas) - ext_s32(r_est_v));
                    end
                    OP_N01:  r_n01 <= w_r16[30:0];
                    OP_N11:  r_n11 <= w_r16[30:0];
                    OP_P0DT: r_acc <= 36'(ext_s32(r_p00) + w_r16 + ext_u31(r_n00));
                    OP_P1DD: r_p00 <= sat32(68'(r_acc) + w_r16);
                    OP_P1DT: begin
                        r_p01 <= sat32(ext_s32(r_p01) + w_r16 + ext_u31(r_n01));
                        r_p10 <= sat32(ext_s32(r_p10) + w_r16 + ext_u31(r_n01));
                        r_p11 <= sat32(ext_s32(r_p11) + ext_u31(r_n11));
                        if (w_svar < 0) begin
                            r_s <= '0;
                        end else if (w_svar > 68'sd2147483647) begin
                            r_s <= 31'h7fffffff;
                        end else begin
                            r_s <= w_svar[30:0];
                        end
                    end
                    OP_SQ:   r_sq <= w_prod[62:0];
                    OP_GS:   r_rej <= w_rej;
                    OP_K0R:  r_est_v <= sat32(ext_s32(r_est_v) + w_rf);
                    OP_K1R:  r_est_r <= sat32(ext_s32(r_est_r) + w_rf);
                    OP_K1P0: r_p10 <= sat32(ext_s32(r_p10) - w_rf);
                    OP_K0P0: r_p00 <= sat32(ext_s32(r_p00) - w_rf);
                    OP_K1P1: r_p11 <= sat32(ext_s32(r_p11) - w_rf);
                    OP_K0P1: r_p01 <= sat32(ext_s32(r_p01) - w_rf);
                    default: r_acc <= r_acc;
                endcase
            end
        end
    end

    // output register: load at the end of an item, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else begin
            if (w_fin) begin
                o_out_valid      <= 1'b1;
                o_value_estimate <= r_est_v;
                o_rate_estimate  <= r_est_r;
                o_residual_out   <= r_res;
                o_innovation_var <= r_s;
                o_rejected       <= r_rej;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready) else $error("input taken while sequencer busy");
    a_gate_branch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_step == ST_GATE) && w_rej) |=> (r_step == ST_FIN))
        else $error("rejected item did not skip correction");
    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin |=> (o_out_valid && !r_busy)) else $error("finish did not load result");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step <= ST_FIN)) else $error("sequencer step out of range");
`endif

endmodule
`default_nettype wire

/* rtl/tskf_mul.sv */
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none
module tskf_mul
    import tskf_pkg::*;
(
    input  wire  i_clk,
    input  t_mop i_a,
    input  t_mop i_b,
    output t_wide o_prod
);

    t_wide r_prod;

    // register each product
    always_ff @(posedge i_clk) begin
        r_prod <= 68'(i_a) * 68'(i_b);
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

/* rtl/tskf_div.sv */
// Radix-4 restoring divider for the gain, two quotient bits per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tskf_div
    import tskf_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int DVW  = ((32 + FRAC_BITS + 1) / 2) * 2;
    localparam int ITER = DVW / 2;
    localparam int CW   = $clog2(ITER + 1);

    logic           r_busy;
    logic           r_done;
    logic [CW-1:0]  r_cnt;
    logic [31:0]    r_rem;
    logic [DVW-1:0] r_quo;
    logic [30:0]    r_den;
    logic           r_neg;

    logic [32:0]    w_rem1;
    logic [32:0]    w_rem2;
    logic [31:0]    w_mid;
    logic [31:0]    w_end;
    logic           w_b1;
    logic           w_b2;
    logic [31:0]    w_mag;
    t_wide          w_q;

    // two compare-subtract steps
    always_comb begin
        w_rem1 = {r_rem, r_quo[DVW-1]};
        w_b1   = w_rem1 >= {2'd0, r_den};
        w_mid  = w_b1 ? 32'(w_rem1 - {2'd0, r_den}) : w_rem1[31:0];
        w_rem2 = {w_mid, r_quo[DVW-2]};
        w_b2   = w_rem2 >= {2'd0, r_den};
        w_end  = w_b2 ? 32'(w_rem2 - {2'd0, r_den}) : w_rem2[31:0];
    end

    assign w_mag = i_req.num[31] ? 32'(-{i_req.num[31], i_req.num}) : 32'(i_req.num);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                // load magnitude shifted by the fraction bits
                r_busy <= 1'b1;
                r_cnt  <= CW'(ITER);
                r_rem  <= '0;
                r_quo  <= DVW'(w_mag) << FRAC_BITS;
                r_den  <= i_req.den;
                r_neg  <= i_req.num[31];
            end else if (r_busy) begin
                r_rem <= w_end;
                r_quo <= {r_quo[DVW-3:0], w_b1, w_b2};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // apply sign and clamp
    assign w_q        = $signed(68'(r_quo));
    assign o_rsp.done = r_done;
    assign o_rsp.quot = sat32(r_neg ? -w_q : w_q);

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy) else $error("divider restarted while busy");
    a_done_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while busy");
    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0) else $error("divider count ran out");
`endif

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
// Testbench for the two-state Kalman filter: directed and random items checked against a predictor.
`timescale 1ns / 1ps
module tb;
    import tskf_pkg::*;

    localparam int  FRAC_BITS    = 16;
    localparam int  MIN_STEP     = 66;
    localparam int  DEFAULT_STEP = 655;
    localparam int  SETTLE       = 80;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam longint S32_MAX   = 64'sd2147483647;
    localparam longint S32_MIN   = -64'sd2147483648;
    localparam logic [30:0] U31_MAX = 31'h7fffffff;

    typedef enum logic [1:0] {
        REG_PROC_NOISE = 2'd0,
        REG_MEAS_NOISE = 2'd1,
        REG_COV_INIT   = 2'd2,
        REG_GATE       = 2'd3
    } t_reg_idx;

    typedef struct {
        logic signed [31:0] value;
        logic signed [31:0] rate;
        logic signed [31:0] resid;
        logic        [30:0] var_s;
        logic               rej;
    } t_estimate;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic       [15:0] i_time_step;
    logic signed [31:0] i_accel;
    logic signed [31:0] i_measurement;
    logic              o_out_valid;
    logic              i_out_ready;
    logic signed [31:0] o_value_estimate;
    logic signed [31:0] o_rate_estimate;
    logic signed [31:0] o_residual_out;
    logic       [30:0] o_innovation_var;
    logic              o_rejected;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic        [1:0] i_cfg_index;
    logic       [30:0] i_cfg_data;

    two_state_kalman_filter #(
        .FRAC_BITS(FRAC_BITS), .MIN_STEP(MIN_STEP), .DEFAULT_STEP(DEFAULT_STEP)
    ) dut (.*);

    // filter state mirrored by the predictor
    logic [30:0] q_std, r_std, p_init, gate;
    longint      kf_value, kf_rate;
    longint      kf_cov [4];

    t_estimate   pending_estimates [$];
    int          fail_count;
    longint      cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;

    // clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic longint clamp_s32(input longint x);
        if (x > S32_MAX) return S32_MAX;
        if (x < S32_MIN) return S32_MIN;
        return x;
    endfunction

    // product with a Q0.16 factor, rounded half up
    function automatic longint scale_step(input longint x, input longint d);
        return (x * d + 32768) >>> 16;
    endfunction

    // product of two fixed-point values, rounded half up
    function automatic longint scale_q(input longint a, input longint b);
        return (a * b + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic void reload_cov();
        kf_cov[0] = p_init;
        kf_cov[1] = 0;
        kf_cov[2] = 0;
        kf_cov[3] = p_init;
    endfunction

    function automatic void reset_filter();
        q_std    = 31'd65536;
        r_std    = 31'd65536;
        p_init   = 31'd65536;
        gate     = 31'd251658;
        kf_value = 0;
        kf_rate  = 0;
        reload_cov();
    endfunction

    function automatic void apply_reg(input t_reg_idx idx, input logic [30:0] data);
        case (idx)
            REG_PROC_NOISE: q_std = data;
            REG_MEAS_NOISE: r_std = data;
            REG_COV_INIT: begin
                p_init = data;
                reload_cov();
            end
            REG_GATE: gate = data;
            default: ;
        endcase
    endfunction

    // advance the filter by one item and return the expected result
    function automatic t_estimate kalman_step(input logic [15:0] ts,
                                              input logic signed [31:0] acc,
                                              input logic signed [31:0] meas);
        t_estimate   e;
        longint      dt, dd, half, g00, g01, q2, r2, n00, n01, n11;
        longint      p00, p01, p10, p11, s, res, k0, k1;
        longint unsigned mag;
        logic        rej;
        dt = (ts < MIN_STEP) ? DEFAULT_STEP : ts;
        dd   = (dt * dt + 32768) >> 16;
        half = (dt * dt + 65536) >> 17;
        g00  = (half * half + 32768) >> 16;
        g01  = (half * dt + 32768) >> 16;

        // predict
        kf_value = clamp_s32(kf_value + scale_step(kf_rate, dt) + scale_step(acc, half));
        kf_rate  = clamp_s32(kf_rate + scale_step(acc, dt));
        q2  = clamp_s32(scale_q(q_std, q_std));
        n00 = scale_step(q2, g00);
        n01 = scale_step(q2, g01);
        n11 = scale_step(q2, dd);
        p00 = kf_cov[0]; p01 = kf_cov[1]; p10 = kf_cov[2]; p11 = kf_cov[3];
        kf_cov[0] = clamp_s32(p00 + scale_step(p01 + p10, dt) + scale_step(p11, dd) + n00);
        kf_cov[1] = clamp_s32(p01 + scale_step(p11, dt) + n01);
        kf_cov[2] = clamp_s32(p10 + scale_step(p11, dt) + n01);
        kf_cov[3] = clamp_s32(p11 + n11);

        // update, gated on residual^2 against gate * S
        res = clamp_s32(longint'(meas) - kf_value);
        r2  = clamp_s32(scale_q(r_std, r_std));
        s   = kf_cov[0] + r2;
        if (s < 0) s = 0;
        if (s > S32_MAX) s = S32_MAX;
        if (s == 0) begin
            rej = 1'b1;
        end else begin
            mag = (res < 0) ? -res : res;
            rej = (mag * mag) > (longint'(gate) * s);
        end
        if (!rej) begin
            p00 = kf_cov[0]; p01 = kf_cov[1]; p10 = kf_cov[2]; p11 = kf_cov[3];
            k0 = clamp_s32((p00 * (64'sd1 <<< FRAC_BITS)) / s);
            k1 = clamp_s32((p10 * (64'sd1 <<< FRAC_BITS)) / s);
            kf_value  = clamp_s32(kf_value + scale_q(k0, res));
            kf_rate   = clamp_s32(kf_rate + scale_q(k1, res));
            kf_cov[0] = clamp_s32(p00 - scale_q(k0, p00));
            kf_cov[1] = clamp_s32(p01 - scale_q(k0, p01));
            kf_cov[2] = clamp_s32(p10 - scale_q(k1, p00));
            kf_cov[3] = clamp_s32(p11 - scale_q(k1, p01));
        end
        e.value = kf_value[31:0];
        e.rate  = kf_rate[31:0];
        e.resid = res[31:0];
        e.var_s = s[30:0];
        e.rej   = rej;
        return e;
    endfunction

    // cycle counter and timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // check each result item against the oldest expectation
    always @(posedge i_clk) begin
        t_estimate e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_estimates.size() == 0) begin
                $error("unexpected result item");
                fail_count++;
            end else begin
                e = pending_estimates.pop_front();
                if (o_value_estimate !== e.value) begin
                    $error("value_estimate exp %0d got %0d", e.value, o_value_estimate);
                    fail_count++;
                end
                if (o_rate_estimate !== e.rate) begin
                    $error("rate_estimate exp %0d got %0d", e.rate, o_rate_estimate);
                    fail_count++;
                end
                if (o_residual_out !== e.resid) begin
                    $error("residual_out exp %0d got %0d", e.resid, o_residual_out);
                    fail_count++;
                end
                if (o_innovation_var !== e.var_s) begin
                    $error("innovation_var exp %0d got %0d", e.var_s, o_innovation_var);
                    fail_count++;
                end
                if (o_rejected !== e.rej) begin
                    $error("rejected exp %0d got %0d", e.rej, o_rejected);
                    fail_count++;
                end
            end
        end
    end

    // send one item, idling first at the current rate
    task automatic send_item(input logic [15:0] ts, input logic signed [31:0] acc,
                             input logic signed [31:0] meas);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_time_step   <= ts;
        i_accel       <= acc;
        i_measurement <= meas;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_estimates.push_back(kalman_step(ts, acc, meas));
    endtask

    // drop valid and hold until every expected result has come
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_estimates.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [30:0] data);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // random signed value near x
    function automatic logic signed [31:0] near(input longint x, input int spread);
        return 32'(clamp_s32(x + $signed($urandom_range(2 * spread)) - spread));
    endfunction

    task automatic test_directed();
        send_item(16'd0, 32'sd0, 32'sd0);
        send_item(16'd65, 32'sd65536, 32'sd65536);
        send_item(16'd66, -32'sd65536, 32'sd0);
        send_item(16'd65535, 32'sd0, 32'sd131072);
        send_item(16'd6554, 32'sh7fffffff, 32'sh7fffffff);
        send_item(16'd6554, 32'sh80000000, 32'sh80000000);
        send_item(16'd65535, 32'sh7fffffff, 32'sh80000000);
        send_item(16'd1, 32'sd0, 32'sh7fffffff);
        send_item(16'hffff, 32'sh80000000, 32'sd0);
    endtask

    task automatic test_gate_extremes();
        write_reg(REG_COV_INIT, 31'd65536);
        write_reg(REG_GATE, 31'd0);
        send_item(16'd655, 32'sd0, near(kf_value, 1000));
        send_item(16'd655, 32'sd0, kf_value[31:0]);
        write_reg(REG_GATE, U31_MAX);
        send_item(16'd655, 32'sd0, 32'sh7fffffff);
        send_item(16'd655, 32'sd0, 32'sh80000000);
        write_reg(REG_GATE, 31'd251658);
    endtask

    // zero noise and zero covariance give a zero variance, then maximum noise and covariance
    task automatic test_zero_variance();
        write_reg(REG_PROC_NOISE, 31'd0);
        write_reg(REG_MEAS_NOISE, 31'd0);
        write_reg(REG_COV_INIT, 31'd0);
        send_item(16'd655, 32'sd0, 32'sd100);
        send_item(16'd0, 32'sd65536, 32'sd0);
        write_reg(REG_PROC_NOISE, U31_MAX);
        write_reg(REG_MEAS_NOISE, U31_MAX);
        write_reg(REG_COV_INIT, U31_MAX);
        send_item(16'd65535, 32'sd0, 32'sd0);
        send_item(16'd655, 32'sd0, 32'sh7fffffff);
    endtask

    task automatic test_random(input int n);
        logic [15:0] ts;
        logic signed [31:0] acc, meas;
        int kind;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(99);
            ts   = ($urandom_range(9) == 0) ? 16'($urandom_range(MIN_STEP - 1))
                                            : 16'($urandom_range(65535, MIN_STEP));
            acc  = ($urandom_range(3) == 0) ? $urandom() : near(0, 1 << 18);
            if (kind < 75) meas = near(kf_value, 1 << 17);
            else if (kind < 90) meas = near(kf_value, 1 << 22);
            else meas = $urandom();
            if (kind >= 97) ts = 16'($urandom());
            send_item(ts, acc, meas);
        end
    endtask

    // pause the sender until everything is out, then go on
    task automatic test_drain_pause();
        test_random(10);
        wait_drained();
        test_random(10);
    endtask

    initial begin
        logic [30:0] q_set [5] = '{31'd65536, 31'd0, 31'd6554, 31'd655360, U31_MAX};
        logic [30:0] r_set [5] = '{31'd65536, 31'd3277, U31_MAX, 31'd0, 31'd327680};
        logic [30:0] c_set [5] = '{31'd65536, U31_MAX, 31'd655, 31'd6553600, 31'd0};
        logic [30:0] g_set [5] = '{31'd251658, 31'd1048576, 31'd0, U31_MAX, 31'd65536};
        int idle_send [4] = '{0, 63, 0, 34};
        int idle_recv [4] = '{0, 0, 63, 34};
        fail_count    = 0;
        cycle_count   = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_time_step   = '0;
        i_accel       = '0;
        i_measurement = '0;
        i_out_ready   = 1'b1;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_PROC_NOISE;
        i_cfg_data    = '0;
        reset_filter();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_gate_extremes();
        test_zero_variance();
        for (int b = 0; b < 8; b++) begin
            wait_drained();
            write_reg(REG_PROC_NOISE, q_set[b % 5]);
            write_reg(REG_MEAS_NOISE, r_set[(b + 1) % 5]);
            write_reg(REG_GATE, g_set[b % 5]);
            write_reg(REG_COV_INIT, c_set[b % 5]);
            send_idle_pct  = idle_send[b % 4];
            recv_stall_pct = idle_recv[b % 4];
            test_random(240);
        end
        send_idle_pct  = 34;
        recv_stall_pct = 34;
        test_drain_pause();

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0 && pending_estimates.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
